[rtl/core/qoie_pkg.sv]
package qoie_pkg;

  typedef logic [23:0] pixel_t;
  typedef logic [7:0]  byte_t;

  localparam int unsigned IndexDepth = 64;
  localparam int unsigned HashW      = $clog2(IndexDepth);
  localparam int unsigned HashBias   = (255 * 11) % IndexDepth;

  localparam int unsigned MaxBodyBytes = 5;
  localparam int unsigned QueueDepth   = 2;

  localparam byte_t OP_RUN_BASE = 8'd191;
  localparam byte_t OP_RUN_FULL = 8'd253;
  localparam byte_t OP_RGB      = 8'd254;
  localparam byte_t OP_DIFF     = 8'd64;
  localparam byte_t OP_LUMA     = 8'd160;
  localparam byte_t END_LAST    = 8'd1;
  localparam byte_t END_FILL    = 8'd0;

  localparam logic [5:0] RUN_LIMIT = 6'd62;
  localparam logic [3:0] END_BYTES = 4'd8;

  typedef logic [HashW-1:0] hash_t;

  // One pixel's bytes: up to five body bytes, then the end marker if flagged.
  typedef struct packed {
    logic                                end_mark;
    logic [2:0]                          cnt;
    logic [MaxBodyBytes-1:0][7:0]        bytes;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  function automatic hash_t qoi_hash(input byte_t r, input byte_t g, input byte_t b);
    logic [11:0] s;
    s = {4'b0, r} * 12'd3 + {4'b0, g} * 12'd5 + {4'b0, b} * 12'd7 + 12'(HashBias);
    return s[HashW-1:0];
  endfunction

endpackage

[rtl/core/qoie_ram.sv]
module qoie_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/qoie_front.sv]
module qoie_front import qoie_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  byte_t  red_i,
  input  byte_t  green_i,
  input  byte_t  blue_i,
  input  logic   final_pixel_i,
  output logic   push_o,
  output entry_t push_entry_o,
  input  logic   q_full_i
);

  logic   accept, s1_adv;
  hash_t  in_hash;

  logic   s1_valid_q, s1_valid_d;
  pixel_t s1_pix_q;
  hash_t  s1_hash_q;
  logic   s1_last_q;
  logic   fwd_q;
  pixel_t fwd_pix_q;
  pixel_t prev_q, prev_d;
  logic [5:0] run_q, run_d;
  logic [IndexDepth-1:0] idx_valid_q, idx_valid_d;
  pixel_t ram_rdata, entry_pix;

  logic rep, hit, pre, post;
  logic [5:0] run_inc;
  byte_t pre_byte;
  logic [3:0][7:0] code_b;
  logic [2:0] code_len;
  logic signed [8:0] dr, dg, db;
  logic signed [9:0] drg, dbg;
  logic [8:0] dr2, dg2, db2;
  logic [9:0] drg8, dbg8;
  logic is_diff, is_luma;
  entry_t ent;

  assign in_hash    = qoi_hash(red_i, green_i, blue_i);
  assign in_stall_o = s1_valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign s1_adv     = s1_valid_q && !q_full_i;

  qoie_ram #(
    .Width($bits(pixel_t)),
    .Depth(IndexDepth)
  ) u_index (
    .clk_i  (clk_i),
    .we_i   (s1_adv),
    .waddr_i(s1_hash_q),
    .wdata_i(s1_pix_q),
    .re_i   (accept),
    .raddr_i(in_hash),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    entry_pix = idx_valid_q[s1_hash_q] ? ram_rdata : '0;
    if (fwd_q) begin
      entry_pix = fwd_pix_q;
    end

    rep     = (s1_pix_q == prev_q);
    hit     = (entry_pix == s1_pix_q);
    run_inc = run_q + 6'd1;

    dr   = $signed({1'b0, s1_pix_q[23:16]}) - $signed({1'b0, prev_q[23:16]});
    dg   = $signed({1'b0, s1_pix_q[15:8]})  - $signed({1'b0, prev_q[15:8]});
    db   = $signed({1'b0, s1_pix_q[7:0]})   - $signed({1'b0, prev_q[7:0]});
    drg  = $signed({dr[8], dr}) - $signed({dg[8], dg});
    dbg  = $signed({db[8], db}) - $signed({dg[8], dg});
    dr2  = dr + 9'sd2;
    dg2  = dg + 9'sd2;
    db2  = db + 9'sd2;
    drg8 = drg + 10'sd8;
    dbg8 = dbg + 10'sd8;

    is_diff = (dr >= -9'sd2) && (dr <= 9'sd1) && (dg >= -9'sd2) && (dg <= 9'sd1) &&
              (db >= -9'sd2) && (db <= 9'sd1);
    is_luma = (dg >= -9'sd32) && (dg <= 9'sd31) && (drg >= -10'sd8) &&
              (drg <= 10'sd7) && (dbg >= -10'sd8) && (dbg <= 10'sd7);

    code_b   = '0;
    code_len = 3'd0;
    if (rep) begin
      pre      = (run_inc == RUN_LIMIT);
      pre_byte = OP_RUN_FULL;
      run_d    = pre ? 6'd0 : run_inc;
    end else begin
      pre      = (run_q != 6'd0);
      pre_byte = OP_RUN_BASE + {2'b0, run_q};
      run_d    = 6'd0;
      priority if (hit) begin
        code_b[0] = {2'b0, s1_hash_q};
        code_len  = 3'd1;
      end else if (is_diff) begin
        code_b[0] = OP_DIFF | {2'b0, dr2[1:0], dg2[1:0], db2[1:0]};
        code_len  = 3'd1;
      end else if (is_luma) begin
        code_b[0] = OP_LUMA + dg[7:0];
        code_b[1] = {drg8[3:0], dbg8[3:0]};
        code_len  = 3'd2;
      end else begin
        code_b   = {s1_pix_q[7:0], s1_pix_q[15:8], s1_pix_q[23:16], OP_RGB};
        code_len = 3'd4;
      end
    end
    post = s1_last_q && rep && (run_d != 6'd0);

    ent          = '0;
    ent.end_mark = s1_last_q;
    if (post) begin
      ent.bytes[0] = OP_RUN_BASE + {2'b0, run_d};
      ent.cnt      = 3'd1;
    end else if (pre) begin
      ent.bytes = {code_b, pre_byte};
      ent.cnt   = code_len + 3'd1;
    end else begin
      ent.bytes = {8'h00, code_b};
      ent.cnt   = code_len;
    end

    prev_d      = prev_q;
    idx_valid_d = idx_valid_q;
    if (s1_last_q) begin
      prev_d      = '0;
      run_d       = 6'd0;
      idx_valid_d = '0;
    end else begin
      prev_d                 = s1_pix_q;
      idx_valid_d[s1_hash_q] = 1'b1;
    end

    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  assign push_o       = s1_adv && ((ent.cnt != 3'd0) || ent.end_mark);
  assign push_entry_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      prev_q      <= '0;
      run_q       <= '0;
      idx_valid_q <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        fwd_q <= s1_adv && !s1_last_q && (s1_hash_q == in_hash);
      end
      if (s1_adv) begin
        prev_q      <= prev_d;
        run_q       <= run_d;
        idx_valid_q <= idx_valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= {red_i, green_i, blue_i};
      s1_hash_q <= in_hash;
      s1_last_q <= final_pixel_i;
      fwd_pix_q <= s1_pix_q;
    end
  end

endmodule

[rtl/core/qoie_fifo.sv]
module qoie_fifo import qoie_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output head_t  head_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  entry_t             slot_q [QueueDepth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]      level_q, level_d;
  logic               do_push, do_pop;

  assign full_o       = (level_q == (PtrW+1)'(QueueDepth));
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && (level_q != '0);
  assign head_o.valid = (level_q != '0);
  assign head_o.entry = slot_q[rd_ptr_q];

  always_comb begin
    level_d = level_q;
    unique case ({do_push, do_pop})
      2'b10:   level_d = level_q + 1'b1;
      2'b01:   level_d = level_q - 1'b1;
      default: level_d = level_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      level_q <= level_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

[rtl/core/qoie_back.sv]
module qoie_back import qoie_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  head_t head_i,
  output logic  pop_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output byte_t code_byte_o,
  output logic  last_of_run_o
);

  logic [3:0] pos_q, total;
  logic       is_last, load;
  logic       out_valid_q;
  byte_t      byte_d, byte_q;
  logic       last_q;

  always_comb begin
    total   = {1'b0, head_i.entry.cnt} + (head_i.entry.end_mark ? END_BYTES : 4'd0);
    is_last = (pos_q == total - 4'd1);
    if (pos_q < {1'b0, head_i.entry.cnt}) begin
      byte_d = head_i.entry.bytes[pos_q[2:0]];
    end else if (is_last) begin
      byte_d = END_LAST;
    end else begin
      byte_d = END_FILL;
    end
  end

  assign load          = head_i.valid && (!out_valid_q || !out_stall_i);
  assign pop_o         = load && is_last;
  assign out_valid_o   = out_valid_q;
  assign code_byte_o   = byte_q;
  assign last_of_run_o = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        pos_q       <= is_last ? 4'd0 : pos_q + 4'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      last_q <= is_last;
    end
  end

endmodule

[rtl/core/qoi_rgb_pixel_encoder_core.sv]
// QOI encoder for RGB pixels, header not included. One pixel is taken per
// cycle while in_stall_o is low and one code byte is delivered per cycle
// while out_stall_i is low; a run, index or diff code is one byte, luma
// two, full RGB four, and the end marker after the final pixel adds eight,
// while repeated pixels that only extend a run produce no output byte. The
// single byte-wide output port sets the sustained rate; a two-entry queue
// between classification and byte output absorbs short bursts before the
// input stalls. With the queue empty, a pixel passes from its input registers
// through the queue into the output byte register. The 64-entry pixel index
// is cleared at once on reset and after each final pixel, so the next image
// can follow without a gap.
module qoi_rgb_pixel_encoder_core import qoie_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  byte_t red_i,
  input  byte_t green_i,
  input  byte_t blue_i,
  input  logic  final_pixel_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output byte_t code_byte_o,
  output logic  last_of_run_o
);

  logic   push, q_full, pop;
  entry_t push_entry;
  head_t  head;

  qoie_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .final_pixel_i(final_pixel_i),
    .push_o       (push),
    .push_entry_o (push_entry),
    .q_full_i     (q_full)
  );

  qoie_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_o      (head)
  );

  qoie_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_byte_o  (code_byte_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

[rtl/core/qoie_checker.sv]
module qoie_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i,
  input logic       final_pixel_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] code_byte_o,
  input logic       last_of_run_o
);

  logic seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      seen_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(code_byte_o) && $stable(last_of_run_o))
    else $error("output payload changed while stalled");

  a_stall_backed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no byte on the output");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> seen_q)
    else $error("output byte before any pixel transfer");

endmodule

bind qoi_rgb_pixel_encoder_core qoie_checker u_qoie_checker (.*);
